// ===== src/idist_pkg.sv =====
// ----------------------------------------------------------------------------
// idist_pkg
// Shared constants and types for the image L1/L2 distance block.
// ----------------------------------------------------------------------------
package idist_pkg;

    localparam int INPUT_CHANNELS  = 4;   // channel fields carried per pixel
    localparam int SUM_BITS        = 42;
    localparam int METRIC_BITS     = 34;
    localparam int SEEN_BITS       = 25;
    localparam int FRAC_BITS       = 8;
    localparam int ROOT_IN_BITS    = SUM_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS       = ROOT_IN_BITS / 2;
    localparam int M_TDATA_BITS    = ((METRIC_BITS + SEEN_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NORM_MODE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd1;

    localparam logic       MODE_L1 = 1'b0;
    localparam logic       MODE_L2 = 1'b1;
    localparam logic [2:0] CHANNEL_COUNT_RESET = 3'd4;

    typedef struct packed {
        logic [SUM_BITS-1:0]  sum;
        logic [SEEN_BITS-1:0] seen;
        logic                 ovf;
        logic                 mode;
    } t_frame;

endpackage

// ===== src/idist_lane.sv =====
// ----------------------------------------------------------------------------
// idist_lane
// One channel lane: absolute difference, optionally squared, registered.
// ----------------------------------------------------------------------------
module idist_lane #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_enable,
    input  logic                      i_mode,
    input  logic [CHANNEL_BITS-1:0]   i_first,
    input  logic [CHANNEL_BITS-1:0]   i_second,
    output logic [2*CHANNEL_BITS-1:0] o_value
);

    logic [CHANNEL_BITS-1:0]   w_diff;
    logic [2*CHANNEL_BITS-1:0] n_value;
    logic [2*CHANNEL_BITS-1:0] r_value;

    always_comb begin
        w_diff = (i_first >= i_second) ? (i_first - i_second) : (i_second - i_first);
        if (!i_enable) begin
            n_value = '0;
        end else if (i_mode == idist_pkg::MODE_L2) begin
            n_value = w_diff * w_diff;
        end else begin
            n_value = (2*CHANNEL_BITS)'(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== src/idist_merge.sv =====
// ----------------------------------------------------------------------------
// idist_merge
// Adds the lane results into the saturating sum, counts pixel pairs and
// hands off the frame totals on the last pixel.
// ----------------------------------------------------------------------------
module idist_merge #(
    parameter int PIXEL_COUNT_BITS = 24,
    parameter int CHANNELS         = 4,
    parameter int CHANNEL_BITS     = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_last,
    input  logic                                 i_mode,
    input  logic [CHANNELS*2*CHANNEL_BITS-1:0]   i_lanes,
    output logic                                 o_frame_valid,
    output idist_pkg::t_frame                    o_frame
);

    localparam int LANE_BITS  = 2 * CHANNEL_BITS;
    localparam int TOTAL_BITS = LANE_BITS + $clog2(CHANNELS) + 1;
    localparam int CNT_BITS   = PIXEL_COUNT_BITS + 1;

    logic                              r_s1_valid;
    logic                              r_s1_last;
    logic                              r_s1_mode;
    logic [idist_pkg::SUM_BITS-1:0]    r_sum;
    logic [CNT_BITS-1:0]               r_count;
    logic                              r_ovf;
    logic                              r_frame_valid;
    idist_pkg::t_frame                 r_frame;

    logic [TOTAL_BITS-1:0]             w_total;
    logic [idist_pkg::SUM_BITS:0]      w_add;
    logic [idist_pkg::SUM_BITS-1:0]    n_sum;
    logic [CNT_BITS-1:0]               n_count;
    logic                              n_ovf;

    always_comb begin
        w_total = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_total = w_total + TOTAL_BITS'(i_lanes[c*LANE_BITS +: LANE_BITS]);
        end
        w_add = {1'b0, r_sum} + (idist_pkg::SUM_BITS+1)'(w_total);
        n_ovf = r_ovf;
        if (w_add[idist_pkg::SUM_BITS]) begin
            n_sum = '1;
            n_ovf = 1'b1;
        end else begin
            n_sum = w_add[idist_pkg::SUM_BITS-1:0];
        end
        if (r_count[PIXEL_COUNT_BITS]) begin
            n_count = r_count;
            n_ovf   = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_sum         <= '0;
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_frame_valid <= 1'b0;
        end else begin
            r_s1_valid    <= i_accept;
            r_frame_valid <= r_s1_valid && r_s1_last;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_last <= i_last;
            r_s1_mode <= i_mode;
        end
        if (r_s1_valid && r_s1_last) begin
            r_frame.sum  <= n_sum;
            r_frame.seen <= idist_pkg::SEEN_BITS'(n_count);
            r_frame.ovf  <= n_ovf;
            r_frame.mode <= r_s1_mode;
        end
    end

    assign o_frame_valid = r_frame_valid;
    assign o_frame       = r_frame;

endmodule

// ===== src/idist_root.sv =====
// ----------------------------------------------------------------------------
// idist_root
// Bit-serial integer square root, one result bit per cycle, truncating.
// ----------------------------------------------------------------------------
module idist_root (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [idist_pkg::ROOT_IN_BITS-1:0] i_value,
    output logic                              o_done,
    output logic [idist_pkg::ROOT_BITS-1:0]    o_root
);

    localparam int IN_BITS   = idist_pkg::ROOT_IN_BITS;
    localparam int ACC_BITS  = IN_BITS + 1;
    localparam int ITER_BITS = $clog2(idist_pkg::ROOT_BITS);
    localparam logic [ITER_BITS-1:0] LAST_ITER = ITER_BITS'(idist_pkg::ROOT_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [ITER_BITS-1:0]  r_iter;
    logic [IN_BITS-1:0]    r_rest;
    logic [ACC_BITS-1:0]   r_acc;
    logic [IN_BITS-1:0]    r_probe;

    logic [ACC_BITS-1:0]   w_trial;
    logic                  w_take;

    always_comb begin
        w_trial = r_acc + ACC_BITS'(r_probe);
        w_take  = ACC_BITS'(r_rest) >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_iter == LAST_ITER) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rest  <= i_value;
            r_acc   <= '0;
            r_probe <= IN_BITS'(1) << (IN_BITS - 2);
            r_iter  <= '0;
        end else if (r_busy) begin
            if (w_take) begin
                r_rest <= r_rest - w_trial[IN_BITS-1:0];
                r_acc  <= (r_acc >> 1) + ACC_BITS'(r_probe);
            end else begin
                r_acc  <= r_acc >> 1;
            end
            r_probe <= r_probe >> 2;
            r_iter  <= r_iter + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_acc[idist_pkg::ROOT_BITS-1:0];

endmodule

// ===== src/image_l1_l2_distance.sv =====
// ----------------------------------------------------------------------------
// image_l1_l2_distance
// Streaming L1 / L2 distance between two images, one pixel pair per request.
// ----------------------------------------------------------------------------
// Pixel pairs are taken one per cycle while the input is not stalled: each channel has its own lane that
// forms the absolute (L1) or squared (L2) difference, and a merge stage adds
// the lanes into a 42-bit saturating sum and counts pairs. After a request
// with tlast the input stalls until the frame result reaches the output
// register; in L2 mode the wait is set by the square root unit that
// resolves one result bit per cycle (29 bits).
// A result waiting at the output does not block the next frame's pixels.
// L2 results carry 8 fraction bits; all values are in units of 1/255.
// ----------------------------------------------------------------------------
module image_l1_l2_distance #(
    parameter int PIXEL_COUNT_BITS = 24,
    parameter int CHANNELS         = 4,
    parameter int CHANNEL_BITS     = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [idist_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [idist_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // pixel pair stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // first_ch0, first_ch1, first_ch2, first_ch3,
    // second_ch0, second_ch1, second_ch2, second_ch3
    input  logic [2*idist_pkg::INPUT_CHANNELS*CHANNEL_BITS-1:0] i_s_tdata,
    input  logic                                  i_s_tlast,     // last_pixel
    // result stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // metric_value, pixels_seen, zero fill
    output logic [idist_pkg::M_TDATA_BITS-1:0]    o_m_tdata,
    output logic                                  o_m_tuser      // saturated
);

    localparam int LANE_BITS = 2 * CHANNEL_BITS;

    logic                                  r_norm_mode;
    logic [2:0]                            r_channel_count;
    logic                                  r_pending;
    logic                                  r_res_valid;
    logic [idist_pkg::METRIC_BITS-1:0]     r_res_metric;
    logic [idist_pkg::SEEN_BITS-1:0]       r_res_seen;
    logic                                  r_res_sat;
    idist_pkg::t_frame                     r_fin;
    logic                                  r_m_valid;
    logic [idist_pkg::M_TDATA_BITS-1:0]    r_m_data;
    logic                                  r_m_user;

    logic                                  w_accept;
    logic                                  w_out_load;
    logic [CHANNELS-1:0]                   w_lane_en;
    logic [CHANNELS*LANE_BITS-1:0]         w_lanes;
    logic                                  w_frame_valid;
    idist_pkg::t_frame                     w_frame;
    logic                                  w_root_start;
    logic                                  w_root_done;
    logic [idist_pkg::ROOT_BITS-1:0]       w_root;
    logic                                  w_l1_clamp;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_pending;
    assign w_accept    = i_s_tvalid && !r_pending;
    assign w_out_load  = r_res_valid && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_mode     <= idist_pkg::MODE_L2;
            r_channel_count <= idist_pkg::CHANNEL_COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                idist_pkg::CFG_NORM_MODE:     r_norm_mode     <= i_cfg_data[0];
                idist_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel count 0 acts as 1, above CHANNELS acts as CHANNELS
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_lane_en[c] = (c == 0) || (r_channel_count > 3'(c));
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        idist_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_load   (w_accept),
            .i_enable (w_lane_en[c]),
            .i_mode   (r_norm_mode),
            .i_first  (i_s_tdata[c*CHANNEL_BITS +: CHANNEL_BITS]),
            .i_second (i_s_tdata[(idist_pkg::INPUT_CHANNELS+c)*CHANNEL_BITS +: CHANNEL_BITS]),
            .o_value  (w_lanes[c*LANE_BITS +: LANE_BITS])
        );
    end

    idist_merge #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .CHANNELS         (CHANNELS),
        .CHANNEL_BITS     (CHANNEL_BITS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_last        (i_s_tlast),
        .i_mode        (r_norm_mode),
        .i_lanes       (w_lanes),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    assign w_root_start = w_frame_valid && (w_frame.mode == idist_pkg::MODE_L2);

    idist_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value ({w_frame.sum, (2*idist_pkg::FRAC_BITS)'(0)}),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign w_l1_clamp = |w_frame.sum[idist_pkg::SUM_BITS-1:idist_pkg::METRIC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_res_valid <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (w_accept && i_s_tlast) begin
                r_pending <= 1'b1;
            end else if (w_out_load) begin
                r_pending <= 1'b0;
            end
            if ((w_frame_valid && w_frame.mode == idist_pkg::MODE_L1) || w_root_done) begin
                r_res_valid <= 1'b1;
            end else if (w_out_load) begin
                r_res_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_valid) begin
            r_fin <= w_frame;
        end
        if (w_frame_valid && w_frame.mode == idist_pkg::MODE_L1) begin
            r_res_metric <= w_l1_clamp ? '1 : w_frame.sum[idist_pkg::METRIC_BITS-1:0];
            r_res_seen   <= w_frame.seen;
            r_res_sat    <= w_frame.ovf || w_l1_clamp;
        end else if (w_root_done) begin
            r_res_metric <= idist_pkg::METRIC_BITS'(w_root);
            r_res_seen   <= r_fin.seen;
            r_res_sat    <= r_fin.ovf;
        end
        if (w_out_load) begin
            r_m_data <= idist_pkg::M_TDATA_BITS'({r_res_seen, r_res_metric});
            r_m_user <= r_res_sat;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule
